>>> design/crt_timing_controller_defines.svh
// assertion macros for the crt timing controller module
// no dependencies
`ifndef CRT_TIMING_CONTROLLER_DEFINES_SVH
`define CRT_TIMING_CONTROLLER_DEFINES_SVH

// implication checked on every edge outside reset
`define CRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crt check failed");

// implication checked in the cycle after the antecedent
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crt check failed");

`endif

>>> design/crt_pkg.sv
// package for the crt timing controller: operation codes, widths, registers
// no dependencies
`timescale 1ns / 1ps

package crt_pkg;

   localparam int AddrWidth = 14;
   localparam logic [AddrWidth-1:0] AddrMask = 14'h3fff;
   localparam logic [7:0] ModeMask = 8'hf3;
   localparam logic [5:0] BlinkModulus = 6'd50;
   localparam logic [5:0] BlinkHalf = 6'd25;
   localparam logic [4:0] VsyncCountMax = 5'd31;
   localparam logic [4:0] VsyncDefault = 5'd16;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_SELECT = 3'd1,
      OP_WRITE  = 3'd2,
      OP_READ   = 3'd3,
      OP_FRAME  = 3'd4,
      OP_PRESET = 3'd5
   } op_type;

   localparam logic [4:0] REG_HTOTAL  = 5'd0;
   localparam logic [4:0] REG_HDISP   = 5'd1;
   localparam logic [4:0] REG_HSPOS   = 5'd2;
   localparam logic [4:0] REG_SYNCW   = 5'd3;
   localparam logic [4:0] REG_VTOTAL  = 5'd4;
   localparam logic [4:0] REG_VADJ    = 5'd5;
   localparam logic [4:0] REG_VDISP   = 5'd6;
   localparam logic [4:0] REG_VSPOS   = 5'd7;
   localparam logic [4:0] REG_MODE    = 5'd8;
   localparam logic [4:0] REG_MAXSCAN = 5'd9;
   localparam logic [4:0] REG_CURST   = 5'd10;
   localparam logic [4:0] REG_CUREND  = 5'd11;
   localparam logic [4:0] REG_SAHI    = 5'd12;
   localparam logic [4:0] REG_SALO    = 5'd13;
   localparam logic [4:0] REG_CAHI    = 5'd14;
   localparam logic [4:0] REG_CALO    = 5'd15;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  data;
      logic [13:0] preset_address;
   } req_type;

   typedef struct packed {
      logic [13:0] refresh_address;
      logic [4:0]  row_address;
      logic        hsync;
      logic        vsync;
      logic        display_enable;
      logic        cursor_active;
      logic        cursor_blink_phase;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

>>> design/crt_if.sv
// valid/ready channel interfaces for requests, results and configuration
// depends on crt_pkg
`timescale 1ns / 1ps

interface crt_req_if import crt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface crt_rsp_if import crt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface crt_csr_if ();
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/crt_timing_controller.sv
// crt timing controller top level: register file, timing counters, output register
// depends on crt_pkg, crt_if and crt_timing_controller_defines.svh
// result valid is registered: it rises in the cycle after the request transfer
// throughput: one item per cycle while rsp.ready holds; the whole update for an item is one pass of logic
// ready stays high while the result register is empty or being drained
// reset (synchronous, active high) clears all registers and counters but the result payload; wrap flags set
`timescale 1ns / 1ps
`include "crt_timing_controller_defines.svh"

module crt_timing_controller import crt_pkg::*; (
   input logic          clock,
   input logic          reset,
   crt_req_if.sink      req,
   crt_rsp_if.source    rsp,
   crt_csr_if.sink      csr
);

   // programmed registers
   logic       personality_ff;
   logic [4:0] sel_ff, sel_in;
   logic [7:0] htot_ff, htot_in, hdisp_ff, hdisp_in, hspos_ff, hspos_in, syncw_ff, syncw_in;
   logic [6:0] vtot_ff, vtot_in, vdisp_ff, vdisp_in, vspos_ff, vspos_in, curst_ff, curst_in;
   logic [4:0] vadj_ff, vadj_in, maxscan_ff, maxscan_in, curend_ff, curend_in;
   logic [7:0] mode_ff, mode_in;
   logic [4:0] vslen_ff, vslen_in;
   logic [13:0] sa_ff, sa_in, ca_ff, ca_in;
   // counters
   logic [7:0] col_ff, col_in;
   logic [4:0] scan_ff, scan_in;
   logic [6:0] row_ff, row_in;
   logic cwrap_ff, cwrap_in, swrap_ff, swrap_in, rwrap_ff, rwrap_in;
   logic [3:0] hsw_ff, hsw_in;
   logic [4:0] vsw_ff, vsw_in, adj_ff, adj_in;
   logic adjact_ff, adjact_in;
   logic [13:0] ma_ff, ma_in, marow_ff, marow_in, manext_ff, manext_in;
   logic hde_ff, hde_in, vde_ff, vde_in, deint_ff, deint_in, deout_ff, deout_in;
   logic hs_ff, hs_in, vs_ff, vs_in, cur_ff, cur_in;
   logic [5:0] blink_ff, blink_in;
   // skew delays, two bits each; the cursor delay also has an expired flag (value -1)
   logic [1:0] curd_ff, curd_in, end_ff, end_in, disd_ff, disd_in;
   logic curexp_ff, curexp_in;
   logic fcs_ff, fcs_in, fco_ff, fco_in, fen_ff, fen_in, fdis_ff, fdis_in;
   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic req_xfer;
   logic [7:0] rd;
   logic [2:0] op;
   logic [7:0] dat;

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_xfer   = req.valid && req.ready;
   assign csr.ready  = 1'b1;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign op  = req.payload.operation;
   assign dat = req.payload.data;

   // one pass of next-state logic per item
   always_comb begin
      logic nx;
      logic [1:0] skew_de;
      sel_in = sel_ff; htot_in = htot_ff; hdisp_in = hdisp_ff; hspos_in = hspos_ff;
      syncw_in = syncw_ff; vtot_in = vtot_ff; vadj_in = vadj_ff; vdisp_in = vdisp_ff;
      vspos_in = vspos_ff; mode_in = mode_ff; maxscan_in = maxscan_ff; curst_in = curst_ff;
      curend_in = curend_ff; sa_in = sa_ff; ca_in = ca_ff; vslen_in = vslen_ff;
      col_in = col_ff; scan_in = scan_ff; row_in = row_ff;
      cwrap_in = cwrap_ff; swrap_in = swrap_ff; rwrap_in = rwrap_ff;
      hsw_in = hsw_ff; vsw_in = vsw_ff; adj_in = adj_ff; adjact_in = adjact_ff;
      ma_in = ma_ff; marow_in = marow_ff; manext_in = manext_ff;
      hde_in = hde_ff; vde_in = vde_ff; deint_in = deint_ff; deout_in = deout_ff;
      hs_in = hs_ff; vs_in = vs_ff; cur_in = cur_ff; blink_in = blink_ff;
      curd_in = curd_ff; curexp_in = curexp_ff; end_in = end_ff; disd_in = disd_ff;
      fcs_in = fcs_ff; fco_in = fco_ff; fen_in = fen_ff; fdis_in = fdis_ff;
      rd = 8'd0;
      nx = 1'b0;
      skew_de = mode_ff[5:4];
      unique case (op)
         OP_TICK: begin
            ma_in  = (ma_ff + 14'd1) & AddrMask;
            col_in = col_ff + 8'd1;
            if (cwrap_ff) begin
               col_in = 8'd0; cwrap_in = 1'b0; hde_in = 1'b1;
               nx = vde_in;
               if (nx && !deint_in) begin
                  end_in = skew_de; if (skew_de != 2'd3) fen_in = 1'b1;
               end
               if (!nx && deint_in) begin disd_in = skew_de; fdis_in = 1'b1; end
               deint_in = nx;
               ma_in = marow_ff;
               scan_in = scan_ff + ((mode_ff[1:0] == 2'd3) ? 5'd2 : 5'd1);
               if (adjact_ff) adj_in = adj_ff + 5'd1;
               if (vs_ff && vsw_ff < VsyncCountMax) vsw_in = vsw_ff + 5'd1;
               if (swrap_ff) begin
                  scan_in = 5'd0; swrap_in = 1'b0;
                  marow_in = manext_ff; ma_in = manext_ff;
                  row_in = row_ff + 7'd1;
                  if (rwrap_ff) begin
                     rwrap_in = 1'b0;
                     if (vadj_ff != 5'd0) begin
                        adjact_in = 1'b1; adj_in = 5'd0;
                     end else begin
                        scan_in = 5'd0; row_in = 7'd0; vde_in = 1'b1;
                        nx = hde_in;
                        if (nx && !deint_in) begin
                           end_in = skew_de; if (skew_de != 2'd3) fen_in = 1'b1;
                        end
                        if (!nx && deint_in) begin disd_in = skew_de; fdis_in = 1'b1; end
                        deint_in = nx;
                        ma_in = sa_ff; marow_in = sa_ff; manext_in = sa_ff;
                     end
                  end
                  if (row_in == vtot_ff && !adjact_in) rwrap_in = 1'b1;
                  if (row_in == vdisp_ff) begin
                     vde_in = 1'b0;
                     if (deint_in) begin disd_in = skew_de; fdis_in = 1'b1; end
                     deint_in = 1'b0;
                  end
                  if (row_in == vspos_ff) vs_in = 1'b1;
               end
               if (vs_in && vsw_in == vslen_ff) begin vsw_in = 5'd0; vs_in = 1'b0; end
               if (adjact_in && adj_in == vadj_ff) begin
                  adjact_in = 1'b0; adj_in = 5'd0;
                  scan_in = 5'd0; row_in = 7'd0; vde_in = 1'b1;
                  nx = hde_in;
                  if (nx && !deint_in) begin
                     end_in = skew_de; if (skew_de != 2'd3) fen_in = 1'b1;
                  end
                  if (!nx && deint_in) begin disd_in = skew_de; fdis_in = 1'b1; end
                  deint_in = nx;
                  ma_in = sa_ff; marow_in = sa_ff; manext_in = sa_ff;
                  if (row_in == vspos_ff) vs_in = 1'b1;
               end
               if (scan_in == maxscan_ff) swrap_in = 1'b1;
            end
            if (col_in == htot_ff) cwrap_in = 1'b1;
            if (col_in == hdisp_ff) begin
               manext_in = ma_in; hde_in = 1'b0;
               if (deint_in) begin disd_in = skew_de; fdis_in = 1'b1; end
               deint_in = 1'b0;
            end
            if (hs_ff) hsw_in = hsw_ff + 4'd1;
            if (col_in == hspos_ff && syncw_ff[3:0] != 4'd0) hs_in = 1'b1;
            if (hs_in && hsw_in == syncw_ff[3:0]) begin hsw_in = 4'd0; hs_in = 1'b0; end
            if (ma_in == ca_ff && scan_in >= curst_ff[4:0] && scan_in <= curend_ff
                && deint_in) begin
               curd_in = mode_ff[7:6]; curexp_in = 1'b0;
               if (mode_ff[7:6] != 2'd3) fcs_in = 1'b1;
            end
            if (fco_in) begin fco_in = 1'b0; cur_in = 1'b0; end
            if (fcs_in) begin
               if (!curexp_in) begin
                  if (curd_in == 2'd0) curexp_in = 1'b1;
                  else curd_in = curd_in - 2'd1;
               end
               if (curexp_in && curst_ff[6:5] != 2'b01) begin
                  fcs_in = 1'b0; fco_in = 1'b1; cur_in = 1'b1;
               end
            end
            if (fen_in) begin
               if (end_in == 2'd0) begin fen_in = 1'b0; deout_in = 1'b1; end
               else end_in = end_in - 2'd1;
            end
            if (fdis_in) begin
               if (disd_in == 2'd0) begin fdis_in = 1'b0; deout_in = 1'b0; end
               else disd_in = disd_in - 2'd1;
            end
         end
         OP_SELECT: sel_in = dat[4:0];
         OP_WRITE: begin
            unique case (sel_ff)
               REG_HTOTAL:  htot_in = dat;
               REG_HDISP:   hdisp_in = dat;
               REG_HSPOS:   hspos_in = dat;
               REG_SYNCW: begin
                  syncw_in = dat;
                  vslen_in = (dat[7:4] == 4'd0) ? VsyncDefault : {1'b0, dat[7:4]};
               end
               REG_VTOTAL:  vtot_in = dat[6:0];
               REG_VADJ:    vadj_in = dat[4:0];
               REG_VDISP:   vdisp_in = dat[6:0];
               REG_VSPOS:   vspos_in = dat[6:0];
               REG_MODE:    mode_in = dat & ModeMask;
               REG_MAXSCAN: maxscan_in = dat[4:0];
               REG_CURST:   curst_in = dat[6:0];
               REG_CUREND:  curend_in = dat[4:0];
               REG_SAHI:    sa_in = {dat[5:0], sa_ff[7:0]};
               REG_SALO:    sa_in = {sa_ff[13:8], dat};
               REG_CAHI:    ca_in = {dat[5:0], ca_ff[7:0]};
               REG_CALO:    ca_in = {ca_ff[13:8], dat};
               default: ;
            endcase
         end
         OP_READ: begin
            unique case (sel_ff)
               REG_SAHI: rd = personality_ff ? {2'b00, sa_ff[13:8]} : 8'd0;
               REG_SALO: rd = personality_ff ? sa_ff[7:0] : 8'd0;
               REG_CAHI: rd = {2'b00, ca_ff[13:8]};
               REG_CALO: rd = ca_ff[7:0];
               default:  rd = 8'd0;
            endcase
         end
         OP_FRAME: blink_in = (blink_ff == BlinkModulus - 6'd1) ? 6'd0 : blink_ff + 6'd1;
         OP_PRESET: begin
            ma_in = req.payload.preset_address;
            marow_in = req.payload.preset_address;
            manext_in = req.payload.preset_address;
         end
         default: ;
      endcase
      rsp_in.refresh_address    = ma_in;
      rsp_in.row_address        = scan_in;
      rsp_in.hsync              = hs_in;
      rsp_in.vsync              = vs_in;
      rsp_in.display_enable     = deout_in;
      rsp_in.cursor_active      = cur_in;
      rsp_in.cursor_blink_phase = blink_in > BlinkHalf;
      rsp_in.read_data          = rd;
   end

   // state update on each request transfer; personality bit loaded on each csr valid
   always_ff @(posedge clock) begin
      if (reset) begin
         personality_ff <= 1'b0;
         sel_ff <= '0; htot_ff <= '0; hdisp_ff <= '0; hspos_ff <= '0; syncw_ff <= '0;
         vtot_ff <= '0; vadj_ff <= '0; vdisp_ff <= '0; vspos_ff <= '0; mode_ff <= '0;
         maxscan_ff <= '0; curst_ff <= '0; curend_ff <= '0; sa_ff <= '0; ca_ff <= '0;
         vslen_ff <= '0; col_ff <= '0; scan_ff <= '0; row_ff <= '0;
         cwrap_ff <= 1'b1; swrap_ff <= 1'b1; rwrap_ff <= 1'b1;
         hsw_ff <= '0; vsw_ff <= '0; adj_ff <= '0; adjact_ff <= 1'b0;
         ma_ff <= '0; marow_ff <= '0; manext_ff <= '0;
         hde_ff <= 1'b0; vde_ff <= 1'b0; deint_ff <= 1'b0; deout_ff <= 1'b0;
         hs_ff <= 1'b0; vs_ff <= 1'b0; cur_ff <= 1'b0; blink_ff <= '0;
         curd_ff <= '0; curexp_ff <= 1'b0; end_ff <= '0; disd_ff <= '0;
         fcs_ff <= 1'b0; fco_ff <= 1'b0; fen_ff <= 1'b0; fdis_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) personality_ff <= csr.data;
         if (req_xfer) begin
            sel_ff <= sel_in; htot_ff <= htot_in; hdisp_ff <= hdisp_in;
            hspos_ff <= hspos_in; syncw_ff <= syncw_in; vtot_ff <= vtot_in;
            vadj_ff <= vadj_in; vdisp_ff <= vdisp_in; vspos_ff <= vspos_in;
            mode_ff <= mode_in; maxscan_ff <= maxscan_in; curst_ff <= curst_in;
            curend_ff <= curend_in; sa_ff <= sa_in; ca_ff <= ca_in; vslen_ff <= vslen_in;
            col_ff <= col_in; scan_ff <= scan_in; row_ff <= row_in;
            cwrap_ff <= cwrap_in; swrap_ff <= swrap_in; rwrap_ff <= rwrap_in;
            hsw_ff <= hsw_in; vsw_ff <= vsw_in; adj_ff <= adj_in; adjact_ff <= adjact_in;
            ma_ff <= ma_in; marow_ff <= marow_in; manext_ff <= manext_in;
            hde_ff <= hde_in; vde_ff <= vde_in; deint_ff <= deint_in; deout_ff <= deout_in;
            hs_ff <= hs_in; vs_ff <= vs_in; cur_ff <= cur_in; blink_ff <= blink_in;
            curd_ff <= curd_in; curexp_ff <= curexp_in; end_ff <= end_in;
            disd_ff <= disd_in; fcs_ff <= fcs_in; fco_ff <= fco_in;
            fen_ff <= fen_in; fdis_ff <= fdis_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (req_xfer) rsp_ff <= rsp_in;
   end

   `CRT_ASSERT_IMPL(a_blink_range, clock, reset, 1'b1, blink_ff < BlinkModulus)
   `CRT_ASSERT_NEXT(a_xfer_fills, clock, reset, req_xfer, rsp_valid_ff)
   `CRT_ASSERT_IMPL(a_cursor_one_char, clock, reset, cur_ff, fco_ff)
   `CRT_ASSERT_IMPL(a_vsync_sat, clock, reset, 1'b1, vsw_ff <= VsyncCountMax)

endmodule
